/* design/i2cm_pkg.sv */
// i2cm_pkg: shared command and status codes and the request and result records
package i2cm_pkg;

    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_BEGIN = 3'd1;
    localparam logic [2:0] CMD_QUEUE = 3'd2;
    localparam logic [2:0] CMD_END   = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;
    localparam logic [2:0] CMD_POP   = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_ADDR_NACK = 2'd2;
    localparam logic [1:0] ST_DATA_NACK = 2'd3;

    localparam logic [15:0] DELAY_RESET = 16'd100;

    typedef struct packed {
        logic [2:0] command;
        logic [6:0] address;
        logic [7:0] data;
        logic [7:0] length;
        logic       stop_flag;
        logic       sda_in;
    } req_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
        logic [5:0] count;
        logic [7:0] read_data;
        logic       available;
        logic       rejected;
    } res_t;

endpackage

/* design/i2cm_core.sv */
// i2cm_core: bus sequencer, transmit and receive queues, one tick per request
module i2cm_core import i2cm_pkg::*; #(
    parameter int TX_DEPTH  = 32,
    parameter int RX_DEPTH  = 32,
    parameter int ACK_POLLS = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  req_t        req,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    output res_t        res
);

    localparam int TIW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int RIW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int TCW = $clog2(TX_DEPTH + 1);
    localparam int RCW = $clog2(RX_DEPTH + 1);

    typedef enum logic [4:0] {
        P_IDLE_REL, P_IDLE_HELD,
        P_ST_A, P_ST_B, P_ST_C,
        P_BIT_SET, P_BIT_HI, P_BIT_LO,
        P_ACK_PRE, P_ACK_HI, P_ACK_POLL, P_ACK_POST,
        P_W_POST, P_SP_A, P_SP_B, P_RS_A, P_RS_B, P_RS_C,
        P_R_GAP, P_RB_HI, P_RB_LO, P_MA_SET, P_MA_HI, P_MA_LO, P_MA_END
    } phase_t;

    logic [7:0] tx_mem [TX_DEPTH];
    logic [7:0] rx_mem [RX_DEPTH];
    logic [7:0] tx_rd_reg, rx_rd_reg;

    phase_t     phase_reg, phase_next;
    logic [15:0] delay_reg;
    logic [17:0] tick_reg, tick_next;
    logic [TIW-1:0] tx_head_reg, tx_head_next;
    logic [TCW-1:0] tx_cnt_reg, tx_cnt_next;
    logic [RIW-1:0] rx_head_reg, rx_head_next;
    logic [RCW-1:0] rx_cnt_reg, rx_cnt_next;
    logic       ovf_reg, ovf_next;
    logic       restart_reg, restart_next;
    logic [3:0] bits_reg, bits_next;
    logic       first_reg, first_next;
    logic       ack_reg, ack_next;
    logic [7:0] sh_reg, sh_next;
    logic [7:0] raddr_reg, raddr_next;
    logic [7:0] rlen_reg, rlen_next;
    logic       rstop_reg, rstop_next;
    logic       rread_reg, rread_next;
    logic [1:0] rs_reg, rs_next;

    logic           tx_we;
    logic [TIW-1:0] tx_waddr;
    logic [7:0]     tx_wdata;
    logic           rx_we;
    logic [RIW-1:0] rx_waddr;

    logic [15:0] dly;
    assign dly = (delay_reg == 16'd0) ? 16'd1 : delay_reg;

    function automatic logic [17:0] units(input logic [15:0] d, input logic [1:0] sh);
        logic [17:0] v;
        v = {2'b00, d};
        return v << sh;
    endfunction

    function automatic logic [TIW-1:0] tx_wrap(input logic [TCW:0] v);
        logic [TCW:0] w;
        w = (v >= (TCW+1)'(TX_DEPTH)) ? v - (TCW+1)'(TX_DEPTH) : v;
        return w[TIW-1:0];
    endfunction

    function automatic logic [RIW-1:0] rx_wrap(input logic [RCW:0] v);
        logic [RCW:0] w;
        w = (v >= (RCW+1)'(RX_DEPTH)) ? v - (RCW+1)'(RX_DEPTH) : v;
        return w[RIW-1:0];
    endfunction

    always_comb begin
        logic        busy;
        logic [17:0] tc;
        logic        ovf_eff;
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        tx_head_next = tx_head_reg;
        tx_cnt_next  = tx_cnt_reg;
        rx_head_next = rx_head_reg;
        rx_cnt_next  = rx_cnt_reg;
        ovf_next     = ovf_reg;
        restart_next = restart_reg;
        bits_next    = bits_reg;
        first_next   = first_reg;
        ack_next     = ack_reg;
        sh_next      = sh_reg;
        raddr_next   = raddr_reg;
        rlen_next    = rlen_reg;
        rstop_next   = rstop_reg;
        rread_next   = rread_reg;
        rs_next      = rs_reg;
        tx_we        = 1'b0;
        tx_waddr     = tx_head_reg;
        tx_wdata     = req.data;
        rx_we        = 1'b0;
        rx_waddr     = rx_wrap({1'b0, RCW'(rx_head_reg)} + {1'b0, rx_cnt_reg});
        tc           = tick_reg;
        ovf_eff      = ovf_reg;
        res          = '0;
        res.scl_out  = 1'b1;
        res.sda_out  = 1'b1;

        unique case (phase_reg)
            P_IDLE_HELD, P_ST_C, P_W_POST, P_MA_END: begin
                res.scl_out = 1'b0; res.sda_out = 1'b0;
            end
            P_ST_B, P_SP_A, P_RS_C: begin
                res.scl_out = 1'b1; res.sda_out = 1'b0;
            end
            P_BIT_SET, P_BIT_LO: begin
                res.scl_out = 1'b0; res.sda_out = sh_reg[7];
            end
            P_BIT_HI: begin
                res.scl_out = 1'b1; res.sda_out = sh_reg[7];
            end
            P_ACK_PRE, P_ACK_POST, P_RS_A, P_R_GAP, P_RB_LO: begin
                res.scl_out = 1'b0; res.sda_out = 1'b1;
            end
            P_MA_SET, P_MA_LO: begin
                res.scl_out = 1'b0; res.sda_out = (rlen_reg == 8'd1);
            end
            P_MA_HI: begin
                res.scl_out = 1'b1; res.sda_out = (rlen_reg == 8'd1);
            end
            default: begin
                res.scl_out = 1'b1; res.sda_out = 1'b1;
            end
        endcase

        busy = (phase_reg != P_IDLE_REL) && (phase_reg != P_IDLE_HELD);

        if (step) begin
            if (busy) begin
                res.rejected = (req.command >= CMD_BEGIN) && (req.command <= CMD_POP);
                if (phase_reg == P_ACK_POLL && !req.sda_in) begin
                    ack_next = 1'b1;
                    tc = 18'd1;
                end
                if (phase_reg == P_RB_HI && tick_reg == 18'd1) begin
                    sh_next = {sh_reg[6:0], req.sda_in};
                end
                if (tc != 18'd0) begin
                    tc = tc - 18'd1;
                end
                tick_next = tc;
                if (tc == 18'd0) begin
                    unique case (phase_reg)
                        P_ST_A: begin
                            phase_next = P_ST_B; tick_next = units(dly, 2'd0);
                        end
                        P_ST_B: begin
                            phase_next = P_ST_C; tick_next = units(dly, 2'd0);
                        end
                        P_ST_C, P_ACK_POST: begin
                            if (phase_reg == P_ACK_POST && rread_reg && !ack_reg) begin
                                phase_next = P_IDLE_HELD; tick_next = '0;
                                rs_next = ST_ADDR_NACK;
                                res.done_res = 1'b1; res.status = ST_ADDR_NACK;
                                res.count = '0;
                            end else if (phase_reg == P_ACK_POST && rread_reg) begin
                                phase_next = P_R_GAP; tick_next = units(dly, 2'd2);
                            end else if (phase_reg == P_ST_C && rread_reg) begin
                                sh_next = raddr_reg; bits_next = 4'd8;
                                phase_next = P_BIT_SET; tick_next = units(dly, 2'd0);
                            end else if (tx_cnt_reg != '0) begin
                                sh_next = tx_rd_reg;
                                tx_head_next = tx_wrap({1'b0, TCW'(tx_head_reg)} + 1'b1);
                                tx_cnt_next = tx_cnt_reg - 1'b1;
                                bits_next = 4'd8;
                                phase_next = P_BIT_SET; tick_next = units(dly, 2'd0);
                            end else begin
                                phase_next = P_W_POST; tick_next = units(dly, 2'd0);
                            end
                        end
                        P_BIT_SET: begin
                            phase_next = P_BIT_HI; tick_next = units(dly, 2'd0);
                        end
                        P_BIT_HI: begin
                            phase_next = P_BIT_LO; tick_next = units(dly, 2'd0);
                        end
                        P_BIT_LO: begin
                            sh_next = {sh_reg[6:0], 1'b0};
                            bits_next = bits_reg - 4'd1;
                            if (bits_reg != 4'd1) begin
                                phase_next = P_BIT_SET; tick_next = units(dly, 2'd0);
                            end else begin
                                ack_next = 1'b0;
                                phase_next = P_ACK_PRE; tick_next = units(dly, 2'd2);
                            end
                        end
                        P_ACK_PRE: begin
                            phase_next = P_ACK_HI; tick_next = units(dly, 2'd2);
                        end
                        P_ACK_HI: begin
                            phase_next = P_ACK_POLL; tick_next = 18'(ACK_POLLS);
                        end
                        P_ACK_POLL: begin
                            if (!rread_reg && !ack_next) begin
                                rs_next = first_reg ? ST_ADDR_NACK : ST_DATA_NACK;
                            end
                            first_next = 1'b0;
                            phase_next = P_ACK_POST; tick_next = units(dly, 2'd2);
                        end
                        P_W_POST: begin
                            if (rstop_reg) begin
                                restart_next = 1'b0;
                                phase_next = P_SP_A;
                            end else begin
                                phase_next = P_RS_A;
                            end
                            tick_next = units(dly, 2'd1);
                        end
                        P_SP_A: begin
                            phase_next = P_SP_B; tick_next = units(dly, 2'd0);
                        end
                        P_SP_B: begin
                            phase_next = P_IDLE_REL; tick_next = '0;
                            res.done_res = 1'b1;
                            if (rread_reg) begin
                                rs_next = ovf_reg ? ST_OVERFLOW : ST_OK;
                                res.status = rs_next;
                                res.count = 6'(rx_cnt_reg);
                            end else begin
                                res.status = rs_reg;
                                res.count = 6'(tx_cnt_reg);
                            end
                        end
                        P_RS_A: begin
                            phase_next = P_RS_B; tick_next = units(dly, 2'd1);
                        end
                        P_RS_B: begin
                            phase_next = P_RS_C; tick_next = units(dly, 2'd0);
                        end
                        P_RS_C: begin
                            restart_next = 1'b1;
                            phase_next = P_IDLE_HELD; tick_next = '0;
                            res.done_res = 1'b1;
                            res.status = rs_reg;
                            res.count = 6'(tx_cnt_reg);
                        end
                        P_RB_HI: begin
                            phase_next = P_RB_LO; tick_next = units(dly, 2'd0);
                        end
                        P_RB_LO: begin
                            bits_next = bits_reg - 4'd1;
                            if (bits_reg != 4'd1) begin
                                phase_next = P_RB_HI; tick_next = units(dly, 2'd0);
                            end else begin
                                if (rx_cnt_reg < RCW'(RX_DEPTH)) begin
                                    rx_we = 1'b1;
                                    rx_cnt_next = rx_cnt_reg + 1'b1;
                                end else begin
                                    ovf_next = 1'b1;
                                end
                                phase_next = P_MA_SET; tick_next = units(dly, 2'd0);
                            end
                        end
                        P_MA_SET: begin
                            phase_next = P_MA_HI; tick_next = units(dly, 2'd0);
                        end
                        P_MA_HI: begin
                            phase_next = P_MA_LO; tick_next = units(dly, 2'd0);
                        end
                        P_MA_LO: begin
                            phase_next = P_MA_END; tick_next = units(dly, 2'd0);
                        end
                        P_R_GAP, P_MA_END: begin
                            if (phase_reg == P_R_GAP) begin
                                rx_head_next = '0; rx_cnt_next = '0; ovf_next = 1'b0;
                                ovf_eff = 1'b0;
                            end else begin
                                rlen_next = rlen_reg - 8'd1;
                            end
                            if (rlen_next != 8'd0) begin
                                sh_next = '0; bits_next = 4'd8;
                                phase_next = P_RB_HI; tick_next = units(dly, 2'd0);
                            end else if (rstop_reg) begin
                                phase_next = P_SP_A; tick_next = units(dly, 2'd1);
                            end else begin
                                phase_next = P_IDLE_HELD; tick_next = '0;
                                rs_next = ovf_eff ? ST_OVERFLOW : ST_OK;
                                res.done_res = 1'b1;
                                res.status = rs_next;
                                res.count = 6'(rx_cnt_next);
                            end
                        end
                        default: begin
                            phase_next = P_IDLE_REL; tick_next = '0;
                            rs_next = ST_OK;
                            res.done_res = 1'b1;
                        end
                    endcase
                end
            end else begin
                unique case (req.command)
                    CMD_BEGIN: begin
                        tx_head_next = '0; ovf_next = 1'b0;
                        tx_we = 1'b1; tx_waddr = '0; tx_wdata = {req.address, 1'b0};
                        tx_cnt_next = TCW'(1);
                        res.done_res = 1'b1;
                        res.count = 6'(tx_cnt_next);
                    end
                    CMD_QUEUE: begin
                        if (tx_cnt_reg < TCW'(TX_DEPTH)) begin
                            tx_we = 1'b1;
                            tx_waddr = tx_wrap({1'b0, TCW'(tx_head_reg)} + {1'b0, tx_cnt_reg});
                            tx_cnt_next = tx_cnt_reg + 1'b1;
                        end else begin
                            ovf_next = 1'b1;
                        end
                        res.done_res = 1'b1;
                        res.status = ovf_next ? ST_OVERFLOW : ST_OK;
                        res.count = 6'(tx_cnt_next);
                    end
                    CMD_END: begin
                        if (ovf_reg) begin
                            res.done_res = 1'b1;
                            res.status = ST_OVERFLOW;
                            res.count = 6'(tx_cnt_reg);
                        end else begin
                            rread_next = 1'b0; rstop_next = req.stop_flag;
                            rs_next = ST_OK; first_next = 1'b1;
                            phase_next = P_ST_A; tick_next = units(dly, 2'd1);
                        end
                    end
                    CMD_READ: begin
                        rread_next = 1'b1; rstop_next = req.stop_flag;
                        rlen_next = req.length;
                        raddr_next = {req.address, 1'b1};
                        rs_next = ST_OK; first_next = 1'b1;
                        if (restart_reg) begin
                            restart_next = 1'b0;
                            phase_next = P_ST_C; tick_next = units(dly, 2'd0);
                        end else begin
                            phase_next = P_ST_A; tick_next = units(dly, 2'd1);
                        end
                    end
                    CMD_POP: begin
                        if (rx_cnt_reg != '0) begin
                            res.read_data = rx_rd_reg;
                            rx_head_next = rx_wrap({1'b0, RCW'(rx_head_reg)} + 1'b1);
                            rx_cnt_next = rx_cnt_reg - 1'b1;
                        end
                        res.done_res = 1'b1;
                        res.count = 6'(rx_cnt_next);
                    end
                    default: begin
                        res.done_res = 1'b0;
                    end
                endcase
            end
            res.busy_res = (phase_next != P_IDLE_REL) && (phase_next != P_IDLE_HELD);
            res.available = (rx_cnt_next != '0);
        end else begin
            res.busy_res = busy;
            res.available = (rx_cnt_reg != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (tx_we) begin
            tx_mem[tx_waddr] <= tx_wdata;
        end
        if (rx_we) begin
            rx_mem[rx_waddr] <= sh_reg;
        end
        tx_rd_reg <= tx_mem[tx_head_next];
        rx_rd_reg <= rx_mem[rx_head_next];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg   <= DELAY_RESET;
            phase_reg   <= P_IDLE_REL;
            tick_reg    <= '0;
            tx_head_reg <= '0;
            tx_cnt_reg  <= '0;
            rx_head_reg <= '0;
            rx_cnt_reg  <= '0;
            ovf_reg     <= 1'b0;
            restart_reg <= 1'b0;
            bits_reg    <= '0;
            first_reg   <= 1'b0;
            ack_reg     <= 1'b0;
            sh_reg      <= '0;
            raddr_reg   <= '0;
            rlen_reg    <= '0;
            rstop_reg   <= 1'b0;
            rread_reg   <= 1'b0;
            rs_reg      <= ST_OK;
        end else begin
            if (cfg_wr_en) begin
                delay_reg <= cfg_wr_data;
            end
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            tx_head_reg <= tx_head_next;
            tx_cnt_reg  <= tx_cnt_next;
            rx_head_reg <= rx_head_next;
            rx_cnt_reg  <= rx_cnt_next;
            ovf_reg     <= ovf_next;
            restart_reg <= restart_next;
            bits_reg    <= bits_next;
            first_reg   <= first_next;
            ack_reg     <= ack_next;
            sh_reg      <= sh_next;
            raddr_reg   <= raddr_next;
            rlen_reg    <= rlen_next;
            rstop_reg   <= rstop_next;
            rread_reg   <= rread_next;
            rs_reg      <= rs_next;
        end
    end

endmodule

/* design/i2c_master_controller.sv */
// i2c_master_controller: open-drain bus master top level with registered result channel
//
// each request on the s_ channel is one bus tick: a command, its operands and
// the sampled sda level. every request yields exactly one result on the m_
// channel carrying the pin drives, busy/done flags, status, queue count, a
// popped byte and the receive-available and rejected flags.
// the result of a request goes to the result register, or to the skid stage while the
// result register holds one not yet taken. one request per cycle is accepted while
// s_ready is high; the bus state, tick counter and queue pointers update in that single
// cycle, and the queue reads come from registered prefetch of the current heads. a
// two-entry output buffer (result register plus skid stage) lets the block take a
// request while a result waits; s_ready drops only when both hold. cfg_wr_en/cfg_wr_data
// set the ticks per bus delay unit, to be written when idle; the block does not check
// this. synchronous active-low reset releases the bus pins, empties both queues, sets
// the delay unit to 100 ticks and drops m_valid; no clearing pass.
module i2c_master_controller import i2cm_pkg::*; #(
    parameter int TX_DEPTH  = 32,
    parameter int RX_DEPTH  = 32,
    parameter int ACK_POLLS = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_command,
    input  logic [6:0]  s_address,
    input  logic [7:0]  s_data,
    input  logic [7:0]  s_length,
    input  logic        s_stop_flag,
    input  logic        s_sda_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_scl_out,
    output logic        m_sda_out,
    output logic        m_busy_res,
    output logic        m_done_res,
    output logic [1:0]  m_status,
    output logic [5:0]  m_count,
    output logic [7:0]  m_read_data,
    output logic        m_available,
    output logic        m_rejected,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    req_t req;
    res_t res;
    res_t out_reg, skid_reg;
    logic out_valid_reg, skid_valid_reg;
    logic step;

    assign req = '{command: s_command, address: s_address, data: s_data,
                   length: s_length, stop_flag: s_stop_flag, sda_in: s_sda_in};
    assign s_ready = !skid_valid_reg;
    assign step = s_valid && s_ready;

    i2cm_core #(
        .TX_DEPTH (TX_DEPTH),
        .RX_DEPTH (RX_DEPTH),
        .ACK_POLLS(ACK_POLLS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .req        (req),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .res        (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_valid_reg && m_ready) begin
            if (skid_valid_reg) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end else if (step) begin
                out_reg <= res;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg) begin
            if (step) begin
                out_reg       <= res;
                out_valid_reg <= 1'b1;
            end
        end else if (step) begin
            skid_reg       <= res;
            skid_valid_reg <= 1'b1;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_scl_out   = out_reg.scl_out;
    assign m_sda_out   = out_reg.sda_out;
    assign m_busy_res  = out_reg.busy_res;
    assign m_done_res  = out_reg.done_res;
    assign m_status    = out_reg.status;
    assign m_count     = out_reg.count;
    assign m_read_data = out_reg.read_data;
    assign m_available = out_reg.available;
    assign m_rejected  = out_reg.rejected;

endmodule

/* verif/testbench.sv */
// testbench: bus-tick requests and per-tick predicted, in-order result checking for the i2c master controller
module testbench;
    import i2cm_pkg::*;

    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;
    localparam int TXD = 32;
    localparam int RXD = 32;
    localparam int POLLS = 10;
    localparam int STALL_LIMIT = 5000;

    typedef enum int {
        PH_IDLE_REL, PH_IDLE_HELD, PH_ST_A, PH_ST_B, PH_ST_C,
        PH_BIT_SET, PH_BIT_HI, PH_BIT_LO,
        PH_ACK_PRE, PH_ACK_HI, PH_ACK_POLL, PH_ACK_POST,
        PH_W_POST, PH_SP_A, PH_SP_B, PH_RS_A, PH_RS_B, PH_RS_C,
        PH_R_GAP, PH_RB_HI, PH_RB_LO, PH_MA_SET, PH_MA_HI, PH_MA_LO, PH_MA_END
    } bus_phase_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_command;
    logic [6:0]  s_address;
    logic [7:0]  s_data;
    logic [7:0]  s_length;
    logic        s_stop_flag;
    logic        s_sda_in;
    logic        m_valid;
    logic        m_ready;
    logic        m_scl_out;
    logic        m_sda_out;
    logic        m_busy_res;
    logic        m_done_res;
    logic [1:0]  m_status;
    logic [5:0]  m_count;
    logic [7:0]  m_read_data;
    logic        m_available;
    logic        m_rejected;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    i2c_master_controller dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_command(s_command), .s_address(s_address), .s_data(s_data),
        .s_length(s_length), .s_stop_flag(s_stop_flag), .s_sda_in(s_sda_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_scl_out(m_scl_out), .m_sda_out(m_sda_out), .m_busy_res(m_busy_res),
        .m_done_res(m_done_res), .m_status(m_status), .m_count(m_count),
        .m_read_data(m_read_data), .m_available(m_available), .m_rejected(m_rejected),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // predicted controller state
    logic [15:0] delay_unit;
    logic [7:0]  tx_mem [TXD];
    int          tx_head, tx_cnt;
    logic [7:0]  rx_mem [RXD];
    int          rx_head, rx_cnt;
    bit          ovf_mark, restart_pend;
    bus_phase_t  ph;
    int          tick_cnt, bits_left;
    bit          first_byte, ack_seen;
    logic [7:0]  shreg, req_addr, req_len;
    bit          req_stop, req_read;
    logic [1:0]  seq_status;
    int          fin_count;

    res_t expected_ticks[$];
    int   send_idle, recv_stall, failures, quiet_cycles;

    function automatic void enter_ph(bus_phase_t p, int units);
        ph = p;
        tick_cnt = units * ((delay_unit == 0) ? 1 : int'(delay_unit));
    endfunction

    function automatic void load_tx_byte();
        shreg = tx_mem[tx_head];
        tx_head = (tx_head + 1) % TXD;
        tx_cnt--;
        bits_left = 8;
        enter_ph(PH_BIT_SET, 1);
    endfunction

    function automatic bit finish_seq(bit held, logic [1:0] st, int cnt);
        ph = held ? PH_IDLE_HELD : PH_IDLE_REL;
        tick_cnt = 0;
        seq_status = st;
        fin_count = cnt;
        return 1'b1;
    endfunction

    function automatic bit read_end();
        if (req_stop) begin
            enter_ph(PH_SP_A, 2);
            return 1'b0;
        end
        return finish_seq(1'b1, ovf_mark ? ST_OVERFLOW : ST_OK, rx_cnt);
    endfunction

    function automatic bit bus_advance();
        case (ph)
            PH_ST_A: enter_ph(PH_ST_B, 1);
            PH_ST_B: enter_ph(PH_ST_C, 1);
            PH_ST_C: begin
                if (req_read) begin
                    shreg = req_addr;
                    bits_left = 8;
                    enter_ph(PH_BIT_SET, 1);
                end else if (tx_cnt > 0) load_tx_byte();
                else enter_ph(PH_W_POST, 1);
            end
            PH_BIT_SET: enter_ph(PH_BIT_HI, 1);
            PH_BIT_HI: enter_ph(PH_BIT_LO, 1);
            PH_BIT_LO: begin
                shreg = shreg << 1;
                bits_left--;
                if (bits_left > 0) enter_ph(PH_BIT_SET, 1);
                else begin
                    ack_seen = 1'b0;
                    enter_ph(PH_ACK_PRE, 4);
                end
            end
            PH_ACK_PRE: enter_ph(PH_ACK_HI, 4);
            PH_ACK_HI: begin
                ph = PH_ACK_POLL;
                tick_cnt = POLLS;
            end
            PH_ACK_POLL: begin
                if (!req_read && !ack_seen) seq_status = first_byte ? ST_ADDR_NACK : ST_DATA_NACK;
                first_byte = 1'b0;
                enter_ph(PH_ACK_POST, 4);
            end
            PH_ACK_POST: begin
                if (req_read) begin
                    if (!ack_seen) return finish_seq(1'b1, ST_ADDR_NACK, 0);
                    enter_ph(PH_R_GAP, 4);
                end else if (tx_cnt > 0) load_tx_byte();
                else enter_ph(PH_W_POST, 1);
            end
            PH_W_POST: begin
                if (req_stop) begin
                    restart_pend = 1'b0;
                    enter_ph(PH_SP_A, 2);
                end else enter_ph(PH_RS_A, 2);
            end
            PH_SP_A: enter_ph(PH_SP_B, 1);
            PH_SP_B: begin
                if (req_read) return finish_seq(1'b0, ovf_mark ? ST_OVERFLOW : ST_OK, rx_cnt);
                return finish_seq(1'b0, seq_status, tx_cnt);
            end
            PH_RS_A: enter_ph(PH_RS_B, 2);
            PH_RS_B: enter_ph(PH_RS_C, 1);
            PH_RS_C: begin
                restart_pend = 1'b1;
                return finish_seq(1'b1, seq_status, tx_cnt);
            end
            PH_R_GAP: begin
                rx_head = 0;
                rx_cnt = 0;
                ovf_mark = 1'b0;
                if (req_len == 0) return read_end();
                shreg = '0;
                bits_left = 8;
                enter_ph(PH_RB_HI, 1);
            end
            PH_RB_HI: enter_ph(PH_RB_LO, 1);
            PH_RB_LO: begin
                bits_left--;
                if (bits_left > 0) begin
                    enter_ph(PH_RB_HI, 1);
                    return 1'b0;
                end
                if (rx_cnt < RXD) begin
                    rx_mem[(rx_head + rx_cnt) % RXD] = shreg;
                    rx_cnt++;
                end else ovf_mark = 1'b1;
                enter_ph(PH_MA_SET, 1);
            end
            PH_MA_SET: enter_ph(PH_MA_HI, 1);
            PH_MA_HI: enter_ph(PH_MA_LO, 1);
            PH_MA_LO: enter_ph(PH_MA_END, 1);
            PH_MA_END: begin
                req_len--;
                if (req_len > 0) begin
                    shreg = '0;
                    bits_left = 8;
                    enter_ph(PH_RB_HI, 1);
                    return 1'b0;
                end
                return read_end();
            end
            default: return finish_seq(1'b0, ST_OK, 0);
        endcase
        return 1'b0;
    endfunction

    function automatic bit bus_busy();
        return ph != PH_IDLE_REL && ph != PH_IDLE_HELD;
    endfunction

    function automatic res_t predict_tick(req_t r);
        res_t o;
        bit nack_bit;
        o = '0;
        nack_bit = (req_len == 1);
        o.scl_out = 1'b1;
        o.sda_out = 1'b1;
        case (ph)
            PH_IDLE_HELD, PH_ST_C, PH_W_POST, PH_MA_END: begin
                o.scl_out = 1'b0; o.sda_out = 1'b0;
            end
            PH_ST_B, PH_SP_A, PH_RS_C: o.sda_out = 1'b0;
            PH_BIT_SET, PH_BIT_LO: begin
                o.scl_out = 1'b0; o.sda_out = shreg[7];
            end
            PH_BIT_HI: o.sda_out = shreg[7];
            PH_ACK_PRE, PH_ACK_POST, PH_RS_A, PH_R_GAP, PH_RB_LO: o.scl_out = 1'b0;
            PH_MA_SET, PH_MA_LO: begin
                o.scl_out = 1'b0; o.sda_out = nack_bit;
            end
            PH_MA_HI: o.sda_out = nack_bit;
            default: ;
        endcase
        if (bus_busy()) begin
            if (r.command >= CMD_BEGIN && r.command <= CMD_POP) o.rejected = 1'b1;
            if (ph == PH_ACK_POLL && !r.sda_in) begin
                ack_seen = 1'b1;
                tick_cnt = 1;
            end
            if (ph == PH_RB_HI && tick_cnt == 1) shreg = {shreg[6:0], r.sda_in};
            if (tick_cnt > 0) tick_cnt--;
            if (tick_cnt == 0 && bus_advance()) begin
                o.done_res = 1'b1;
                o.status = seq_status;
                o.count = fin_count[5:0];
            end
        end else begin
            case (r.command)
                CMD_BEGIN: begin
                    tx_head = 0;
                    ovf_mark = 1'b0;
                    tx_mem[0] = {r.address, 1'b0};
                    tx_cnt = 1;
                    o.done_res = 1'b1;
                    o.count = 6'd1;
                end
                CMD_QUEUE: begin
                    if (tx_cnt < TXD) begin
                        tx_mem[(tx_head + tx_cnt) % TXD] = r.data;
                        tx_cnt++;
                    end else ovf_mark = 1'b1;
                    o.done_res = 1'b1;
                    o.status = ovf_mark ? ST_OVERFLOW : ST_OK;
                    o.count = tx_cnt[5:0];
                end
                CMD_END: begin
                    if (ovf_mark) begin
                        o.done_res = 1'b1;
                        o.status = ST_OVERFLOW;
                        o.count = tx_cnt[5:0];
                    end else begin
                        req_read = 1'b0;
                        req_stop = r.stop_flag;
                        seq_status = ST_OK;
                        first_byte = 1'b1;
                        enter_ph(PH_ST_A, 2);
                    end
                end
                CMD_READ: begin
                    req_read = 1'b1;
                    req_stop = r.stop_flag;
                    req_len = r.length;
                    req_addr = {r.address, 1'b1};
                    seq_status = ST_OK;
                    first_byte = 1'b1;
                    if (restart_pend) begin
                        restart_pend = 1'b0;
                        enter_ph(PH_ST_C, 1);
                    end else enter_ph(PH_ST_A, 2);
                end
                CMD_POP: begin
                    if (rx_cnt > 0) begin
                        o.read_data = rx_mem[rx_head];
                        rx_head = (rx_head + 1) % RXD;
                        rx_cnt--;
                    end
                    o.done_res = 1'b1;
                    o.count = rx_cnt[5:0];
                end
                default: ;
            endcase
        end
        o.busy_res = bus_busy();
        o.available = rx_cnt > 0;
        return o;
    endfunction

    task automatic send_tick(req_t r);
        if ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= r.command;
        s_address <= r.address;
        s_data <= r.data;
        s_length <= r.length;
        s_stop_flag <= r.stop_flag;
        s_sda_in <= r.sda_in;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_ticks.push_back(predict_tick(r));
    endtask

    task automatic send_cmd(logic [2:0] c, logic [6:0] a, logic [7:0] d, logic [7:0] n,
                            logic sf);
        req_t r;
        r.command = c;
        r.address = a;
        r.data = d;
        r.length = n;
        r.stop_flag = sf;
        r.sda_in = 1'($urandom_range(1));
        send_tick(r);
    endtask

    // clocks the bus until the sequence ends, target acks with the given percentage
    task automatic run_bus(int ack_pct, int cmd_pct);
        req_t r;
        while (bus_busy()) begin
            r.command = ($urandom_range(99) < cmd_pct) ? 3'($urandom_range(1, 7)) : CMD_NONE;
            r.address = 7'($urandom);
            r.data = 8'($urandom);
            r.length = 8'($urandom);
            r.stop_flag = 1'($urandom_range(1));
            r.sda_in = (ph == PH_ACK_POLL) ? ($urandom_range(99) >= ack_pct)
                                           : 1'($urandom_range(1));
            send_tick(r);
        end
    endtask

    task automatic set_delay(logic [15:0] v);
        s_valid <= 1'b0;
        wait (expected_ticks.size() == 0);
        repeat (4) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        delay_unit = v;
    endtask

    task automatic write_seq(int nbytes, logic sf, int ack_pct);
        send_cmd(CMD_BEGIN, 7'($urandom), 8'($urandom), 8'($urandom), 1'($urandom_range(1)));
        repeat (nbytes)
            send_cmd(CMD_QUEUE, 7'($urandom), 8'($urandom), 8'($urandom),
                     1'($urandom_range(1)));
        send_cmd(CMD_END, 7'($urandom), 8'($urandom), 8'($urandom), sf);
        run_bus(ack_pct, 3);
    endtask

    task automatic read_seq(logic [7:0] n, logic sf, int ack_pct);
        send_cmd(CMD_READ, 7'($urandom), 8'($urandom), n, sf);
        run_bus(ack_pct, 3);
    endtask

    task automatic test_local_commands();
        send_cmd(CMD_POP, 7'h00, 8'h00, 8'h00, 1'b0);
        send_cmd(CMD_RSVD6, 7'h7f, 8'hff, 8'hff, 1'b1);
        send_cmd(CMD_RSVD7, 7'h00, 8'h00, 8'h00, 1'b0);
        send_cmd(CMD_NONE, 7'h7f, 8'hff, 8'hff, 1'b1);
        send_cmd(CMD_BEGIN, 7'h7f, 8'h00, 8'h00, 1'b0);
        repeat (TXD + 1) send_cmd(CMD_QUEUE, 7'($urandom), 8'($urandom), 8'($urandom), 1'b1);
        // end refused while overflowed
        send_cmd(CMD_END, 7'h00, 8'h00, 8'h00, 1'b1);
        send_cmd(CMD_BEGIN, 7'h00, 8'hff, 8'h00, 1'b0);
    endtask

    task automatic test_write();
        write_seq(1, 1'b1, 100);
        write_seq(1, 1'b1, 0);
        write_seq(1, 1'b0, 100);
    endtask

    task automatic test_read();
        read_seq(8'd1, 1'b1, 100);
        send_cmd(CMD_POP, 7'h00, 8'h00, 8'h00, 1'b0);
        read_seq(8'd0, 1'b0, 100);
        read_seq(8'd1, 1'b0, 0);
        read_seq(8'(RXD + 1), 1'b1, 100);
        repeat (3) send_cmd(CMD_POP, 7'h00, 8'h00, 8'h00, 1'b0);
    endtask

    task automatic test_delay_extremes();
        set_delay(16'd65535);
        send_cmd(CMD_BEGIN, 7'h55, 8'h00, 8'h00, 1'b0);
        send_cmd(CMD_QUEUE, 7'h00, 8'ha5, 8'h00, 1'b1);
        send_cmd(CMD_POP, 7'h00, 8'h00, 8'h00, 1'b0);
        set_delay(16'd0);
        write_seq(0, 1'b1, 100);
        set_delay(16'd1);
    endtask

    task automatic test_random(int n);
        int i;
        int k;
        for (i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 40) write_seq($urandom_range(0, 3), 1'($urandom_range(1)),
                                  $urandom_range(99) < 85 ? 95 : 20);
            else if (k < 75) begin
                read_seq(8'($urandom_range(0, 3)), 1'($urandom_range(1)),
                         $urandom_range(99) < 85 ? 95 : 20);
                repeat ($urandom_range(0, 3))
                    send_cmd(CMD_POP, 7'($urandom), 8'($urandom), 8'($urandom),
                             1'($urandom_range(1)));
            end else begin
                send_cmd(3'($urandom_range(0, 7)), 7'($urandom), 8'($urandom),
                         8'($urandom_range(0, 3)), 1'($urandom_range(1)));
                run_bus(80, 10);
            end
        end
    endtask

    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $display("%0t %s expected %0d actual %0d", $time, name, exp_v, act_v);
            failures++;
        end
    endfunction

    always @(posedge aclk) begin
        res_t e;
        if (aresetn) begin
            m_ready <= ($urandom_range(99) >= recv_stall);
            if (m_valid && m_ready) begin
                if (expected_ticks.size() == 0) begin
                    $display("%0t unexpected result", $time);
                    failures++;
                end else begin
                    e = expected_ticks.pop_front();
                    check_field("scl_out", e.scl_out, m_scl_out);
                    check_field("sda_out", e.sda_out, m_sda_out);
                    check_field("busy_res", e.busy_res, m_busy_res);
                    check_field("done_res", e.done_res, m_done_res);
                    check_field("status", e.status, m_status);
                    check_field("count", e.count, m_count);
                    check_field("read_data", e.read_data, m_read_data);
                    check_field("available", e.available, m_available);
                    check_field("rejected", e.rejected, m_rejected);
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_command <= CMD_NONE;
        s_address <= '0;
        s_data <= '0;
        s_length <= '0;
        s_stop_flag <= 1'b0;
        s_sda_in <= 1'b1;
        m_ready <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        failures = 0;
        quiet_cycles = 0;
        delay_unit = DELAY_RESET;
        tx_head = 0; tx_cnt = 0; rx_head = 0; rx_cnt = 0;
        ovf_mark = 0; restart_pend = 0; ph = PH_IDLE_REL; tick_cnt = 0; bits_left = 0;
        first_byte = 0; ack_seen = 0; shreg = '0; req_addr = '0; req_len = '0;
        req_stop = 0; req_read = 0; seq_status = ST_OK; fin_count = 0;
        send_idle = 18;
        recv_stall = 70;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_local_commands();
        test_delay_extremes();
        test_write();
        send_idle = 70;
        recv_stall = 18;
        test_read();
        send_idle = 0;
        recv_stall = 0;
        test_random(2);
        s_valid <= 1'b0;
        wait (expected_ticks.size() == 0);
        repeat (10) @(posedge aclk);
        if (failures == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
